// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int SPQ_DEPTH = 16;

    typedef enum logic [1:0] {
        CMD_ENQUEUE  = 2'd0,
        CMD_DEQUEUE  = 2'd1,
        CMD_CONTAINS = 2'd2
    } t_command;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ,
        ST_ENQ_FIN,
        ST_DEQ,
        ST_CON
    } t_state;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        item_handle;
        logic signed [31:0] priority_req;
    } t_cmd_item;

    typedef struct packed {
        logic [31:0] head_handle;
        logic        hit;
        logic [4:0]  entry_count;
        logic        is_empty;
    } t_result_item;

    // One stored queue entry.
    typedef struct packed {
        logic [31:0]        handle;
        logic signed [31:0] prio;
    } t_entry;

endpackage

// ===== rtl/spq_ram.sv =====
// Entry memory: one write port, one registered read port.
module spq_ram
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/spq_ctrl.sv =====
// Command sequencer: ring pointers, insertion shift, search and result register.
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  t_cmd_item     i_cmd,
    output logic          o_valid,
    output t_result_item  o_result,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output t_entry        o_wdata,
    output logic [AW-1:0] o_raddr,
    input  t_entry        i_rdata
);

    t_state       r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_left, n_left;
    t_cmd_item    r_cmd, n_cmd;
    t_result_item r_res, n_res;
    logic         r_valid, n_valid;

    logic [AW-1:0] w_tail;
    logic          w_full;
    logic          w_empty;
    logic          w_move;   // stored entry sorts after the new one
    logic          w_match;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p,
                                              input logic [CW-1:0] c);
        logic [AW:0] s;
        s = (AW + 1)'(p) + (AW + 1)'(c);
        if (s >= (AW + 1)'(DEPTH)) begin
            s = s - (AW + 1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign w_tail  = ptr_add(r_head, r_count);
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_move  = ($signed(i_rdata.prio) > $signed(r_cmd.priority_req));
    assign w_match = (i_rdata.handle == r_cmd.item_handle);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_cmd.command)
                        CMD_ENQUEUE:  if (!w_full && !w_empty) n_state = ST_ENQ;
                        CMD_DEQUEUE:  if (!w_empty) n_state = ST_DEQ;
                        CMD_CONTAINS: if (!w_empty) n_state = ST_CON;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ENQ: begin
                if (!w_move) begin
                    n_state = ST_IDLE;
                end else if (r_left == CW'(1)) begin
                    n_state = ST_ENQ_FIN;
                end
            end
            ST_ENQ_FIN: n_state = ST_IDLE;
            ST_DEQ:     n_state = ST_IDLE;
            ST_CON: begin
                if (w_match || r_left == CW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_pos   = r_pos;
        n_left  = r_left;
        n_cmd   = r_cmd;
        n_res   = r_res;
        n_valid = 1'b0;
        o_we    = 1'b0;
        o_waddr = r_pos;
        o_wdata = '{handle: r_cmd.item_handle, prio: r_cmd.priority_req};
        o_raddr = r_head;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                    n_res.head_handle = '0;
                    n_res.hit         = 1'b0;
                    case (i_cmd.command)
                        CMD_ENQUEUE: begin
                            if (w_full) begin
                                n_valid = 1'b1;
                            end else if (w_empty) begin
                                o_we      = 1'b1;
                                o_waddr   = r_head;
                                o_wdata   = '{handle: i_cmd.item_handle,
                                              prio:   i_cmd.priority_req};
                                n_count   = r_count + 1'b1;
                                n_res.hit = 1'b1;
                                n_valid   = 1'b1;
                            end else begin
                                // walk back from the tail
                                n_pos   = w_tail;
                                o_raddr = ptr_dec(w_tail);
                                n_left  = r_count;
                            end
                        end
                        CMD_DEQUEUE: begin
                            if (w_empty) n_valid = 1'b1;
                        end
                        CMD_CONTAINS: begin
                            if (w_empty) begin
                                n_valid = 1'b1;
                            end else begin
                                n_pos  = r_head;
                                n_left = r_count;
                            end
                        end
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            ST_ENQ: begin
                // i_rdata holds entry at r_pos-1
                o_we = 1'b1;
                if (w_move) begin
                    o_wdata = i_rdata;
                    n_pos   = ptr_dec(r_pos);
                    n_left  = r_left - 1'b1;
                    o_raddr = ptr_dec(ptr_dec(r_pos));
                end else begin
                    n_count   = r_count + 1'b1;
                    n_res.hit = 1'b1;
                    n_valid   = 1'b1;
                end
            end
            ST_ENQ_FIN: begin
                o_we      = 1'b1;
                n_count   = r_count + 1'b1;
                n_res.hit = 1'b1;
                n_valid   = 1'b1;
            end
            ST_DEQ: begin
                n_res.head_handle = i_rdata.handle;
                n_res.hit         = 1'b1;
                n_head            = ptr_inc(r_head);
                n_count           = r_count - 1'b1;
                n_valid           = 1'b1;
            end
            ST_CON: begin
                if (w_match) begin
                    n_res.hit = 1'b1;
                    n_valid   = 1'b1;
                end else if (r_left == CW'(1)) begin
                    n_valid = 1'b1;
                end else begin
                    n_pos   = ptr_inc(r_pos);
                    o_raddr = ptr_inc(r_pos);
                    n_left  = r_left - 1'b1;
                end
            end
            default: ;
        endcase
        if (r_state == ST_CON && !n_valid) begin
            o_raddr = ptr_inc(r_pos);
        end
        n_res.entry_count = 5'(n_count);
        n_res.is_empty    = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_left <= n_left;
        r_cmd  <= n_cmd;
        r_res  <= n_res;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted min-priority queue: entries kept in order in a ring buffer memory.
// Rejected or no-op commands and enqueue into an empty queue answer directly from idle;
//   dequeue reads the head entry, then answers; contains examines entries from the head
//   until a match or the last one; enqueue reads back from the tail and writes the new item last.
// Throughput: one command at a time; start is taken whenever busy is low.
// Reset (synchronous, active low) empties the queue; o_valid pulses one cycle per result.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  t_cmd_item    i_cmd,
    output logic         o_valid,
    output t_result_item o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Memory holds entries from the head pointer onward in ring order,
    // lowest priority first. Dequeue just advances the head. Enqueue reads
    // backward from the tail; each entry that sorts after the new item is
    // written one slot further back while the next read is in flight, and
    // the new item lands in the gap. Equal priorities stay ahead of the
    // new item, so arrival order holds among equals.
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    t_entry        w_wdata;
    t_entry        w_rdata;

    spq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .o_result (o_result),
        .o_we     (w_we),
        .o_waddr  (w_waddr),
        .o_wdata  (w_wdata),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata)
    );

    spq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

endmodule
